// ----- hdl/rwle_pkg.sv -----
// Shared types and constants of the register write log encoder.
// Command codes, log byte codes and the structs passed between modules.
// No dependencies.
package rwle_pkg;

    localparam logic [3:0] CMD_TICK   = 4'd0;
    localparam logic [3:0] CMD_BANK   = 4'd1;
    localparam logic [3:0] CMD_BASE   = 4'd2;
    localparam logic [3:0] CMD_CHIP_A = 4'd3;
    localparam logic [3:0] CMD_CHIP_B = 4'd4;
    localparam logic [3:0] CMD_CHIP_C = 4'd5;
    localparam logic [3:0] CMD_CHIP_D = 4'd6;
    localparam logic [3:0] CMD_CHIP_E = 4'd7;
    localparam logic [3:0] CMD_CHIP_F = 4'd8;
    localparam logic [3:0] CMD_INIT   = 4'd9;
    localparam logic [3:0] CMD_END    = 4'd10;

    localparam logic [7:0] WAIT_SHORT = 8'hFF;
    localparam logic [7:0] WAIT_LONG  = 8'hFE;
    localparam logic [7:0] END_MARK   = 8'hFD;
    localparam logic [7:0] BANK_OP    = 8'h3C;
    localparam logic [7:0] CHIP_A_OP  = 8'h16;
    localparam logic [7:0] CHIP_B_OP  = 8'h1F;
    localparam logic [7:0] CHIP_D_OP  = 8'h20;
    localparam logic [7:0] CHIP_E_OP  = 8'h36;
    localparam logic [7:0] CHIP_F_OP  = 8'h37;
    localparam logic [7:0] SLOT_NONE  = 8'hFF;

    localparam logic [15:0] CHIP_A_BASE = 16'h9000;
    localparam logic [15:0] CHIP_D_BASE = 16'h5000;
    localparam logic [31:0] VARLEN_G4   = 32'h0FFF_FFFF;
    localparam logic [31:0] VARLEN_G3   = 32'h001F_FFFF;
    localparam logic [31:0] VARLEN_G2   = 32'h0000_3FFF;
    localparam logic [31:0] VARLEN_G1   = 32'h0000_007F;

    localparam int MAX_BYTES = 9;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [15:0] address;
        logic [7:0]  value;
        logic [31:0] cycle_now;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } log_t;

    typedef struct packed {
        logic       start;
        logic [7:0] id;
    } slot_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] slot;
    } slot_rsp_t;

    typedef struct packed {
        logic                          valid;
        logic [3:0]                    count;
        logic [MAX_BYTES-1:0][7:0]     bytes;
    } ser_load_t;

endpackage

// ----- hdl/rwle_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
// Used for the request input and the log byte output; no dependencies.
interface rwle_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/register_write_log_encoder.sv -----
// Register write log encoder: sound-chip register writes in, log bytes out.
// An accepted request steps through the wait and build states before its bytes are loaded
// into the log byte buffer; bank writes first scan the bank table for a match or allocate.
// A request that logs nothing returns to idle without a load; a load also waits for the
// previous bytes to drain, one per cycle while the log byte receiver is ready.
// Reset clears all control state and the bank fill count at once; table RAM needs no clearing.
module register_write_log_encoder import rwle_pkg::*; #(
    parameter int MAX_BANKS = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_en,
    input  logic cfg_data,
    rwle_stream_if.sink   write_req,
    rwle_stream_if.source log_byte
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SLOT  = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_BUILD = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic             sync_mode_reg, sync_mode_next;
    logic             init_done_reg, init_done_next;
    logic [31:0]      synced_reg, synced_next;
    logic [31:0]      pending_reg, pending_next;
    logic [3:0][7:0]  window_reg, window_next;
    logic             emit_reg, emit_next;
    logic             flush_reg, flush_next;
    logic [7:0]       slot_reg, slot_next;
    logic [31:0]      wait_reg, wait_next;
    req_t             item_reg, item_next;

    slot_req_t        slot_req;
    slot_rsp_t        slot_rsp;
    ser_load_t        ser_load;
    logic             ser_ld_ready;
    logic             accept;

    logic [31:0]      vl;
    logic [4:0][6:0]  grp;
    logic [2:0]       vn;
    logic [2:0]       gk;
    logic [5:0][7:0]  wb;
    logic [3:0]       wn;
    logic [2:0][7:0]  cb;
    logic [3:0]       cn;
    logic [3:0]       ci;
    logic [19:0]      a_diff;
    logic [7:0]       a_sel;

    rwle_slot_finder #(
        .MAX_BANKS (MAX_BANKS)
    ) u_slot_finder (
        .clk      (clk),
        .rst_n    (rst_n),
        .slot_req (slot_req),
        .slot_rsp (slot_rsp)
    );

    rwle_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld       (ser_load),
        .ld_ready (ser_ld_ready),
        .log_byte (log_byte)
    );

    assign write_req.ready = (state_reg == S_IDLE);
    assign accept          = write_req.valid && write_req.ready;

    always_comb
    begin
        state_next     = state_reg;
        sync_mode_next = cfg_en ? cfg_data : sync_mode_reg;
        init_done_next = init_done_reg;
        synced_next    = synced_reg;
        pending_next   = pending_reg;
        window_next    = window_reg;
        emit_next      = emit_reg;
        flush_next     = flush_reg;
        slot_next      = slot_reg;
        wait_next      = wait_reg;
        item_next      = item_reg;
        slot_req       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next  = write_req.payload;
                    flush_next = (write_req.payload.cmd != CMD_END);
                    unique case (write_req.payload.cmd)
                        CMD_TICK:
                        begin
                            if (sync_mode_reg && init_done_reg)
                            begin
                                pending_next = pending_reg + 32'd1;
                            end
                        end
                        CMD_BANK:
                        begin
                            if (write_req.payload.address[3:2] == 2'b11)
                            begin
                                window_next[write_req.payload.address[1:0]] =
                                    write_req.payload.value;
                                slot_req.start = 1'b1;
                                slot_req.id    = write_req.payload.value;
                                emit_next      = 1'b1;
                                state_next     = S_SLOT;
                            end
                        end
                        CMD_BASE:
                        begin
                            if (write_req.payload.address[15:14] != 2'b11)
                            begin
                                state_next = S_WAIT;
                            end
                            else
                            begin
                                slot_req.start = 1'b1;
                                slot_req.id    =
                                    window_reg[write_req.payload.address[13:12]];
                                emit_next      = 1'b0;
                                state_next     = S_SLOT;
                            end
                        end
                        CMD_CHIP_A:
                        begin
                            if (write_req.payload.address[11:0] < 12'd3)
                            begin
                                state_next = S_WAIT;
                            end
                        end
                        CMD_CHIP_B, CMD_CHIP_C, CMD_CHIP_D, CMD_CHIP_E, CMD_CHIP_F,
                        CMD_END:
                        begin
                            state_next = S_WAIT;
                        end
                        CMD_INIT:
                        begin
                            init_done_next = 1'b1;
                            synced_next    = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SLOT:
            begin
                if (slot_rsp.done)
                begin
                    slot_next  = slot_rsp.slot;
                    state_next = emit_reg ? S_WAIT : S_IDLE;
                end
            end
            S_WAIT:
            begin
                if (flush_reg && init_done_reg)
                begin
                    wait_next = sync_mode_reg ? pending_reg
                                              : item_reg.cycle_now - synced_reg;
                end
                else
                begin
                    wait_next = '0;
                end
                state_next = S_BUILD;
            end
            S_BUILD:
            begin
                if (ser_ld_ready)
                begin
                    if (flush_reg && init_done_reg)
                    begin
                        synced_next  = synced_reg + wait_reg;
                        pending_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Wait bytes: short form, or long marker followed by a varlen of wait - 3.
    always_comb
    begin
        vl = wait_reg - 32'd3;
        for (int k = 0; k < 4; k++)
        begin
            grp[k] = vl[7*k +: 7];
        end
        grp[4] = {3'b000, vl[31:28]};
        vn = 3'd1 + 3'(vl > VARLEN_G1) + 3'(vl > VARLEN_G2) + 3'(vl > VARLEN_G3)
                  + 3'(vl > VARLEN_G4);
        wb = '0;
        gk = '0;
        if (wait_reg == 32'd0)
        begin
            wn = 4'd0;
        end
        else if (wait_reg == 32'd1)
        begin
            wb[0] = WAIT_SHORT;
            wn    = 4'd1;
        end
        else if (wait_reg == 32'd2)
        begin
            wb[0] = WAIT_SHORT;
            wb[1] = WAIT_SHORT;
            wn    = 4'd2;
        end
        else
        begin
            wb[0] = WAIT_LONG;
            for (int j = 0; j < 5; j++)
            begin
                gk = vn - 3'd1 - 3'(j);
                if (3'(j) < vn)
                begin
                    wb[j+1] = {(3'(j) < vn - 3'd1), grp[gk]};
                end
            end
            wn = 4'd1 + 4'(vn);
        end
    end

    // Command bytes.
    always_comb
    begin
        a_diff = {4'b0000, item_reg.address} - {4'b0000, CHIP_A_BASE};
        a_sel  = a_diff[19:12];
        cb     = '0;
        cn     = 4'd0;
        unique case (item_reg.cmd)
            CMD_BANK:
            begin
                cb[0] = BANK_OP + {6'b000000, item_reg.address[1:0]};
                cb[1] = slot_reg;
                cn    = 4'd2;
            end
            CMD_BASE, CMD_CHIP_C:
            begin
                cb[0] = item_reg.address[7:0];
                cb[1] = item_reg.value;
                cn    = 4'd2;
            end
            CMD_CHIP_A:
            begin
                cb[0] = CHIP_A_OP + a_sel + {a_sel[6:0], 1'b0}
                        + {6'b000000, item_reg.address[1:0]};
                cb[1] = item_reg.value;
                cn    = 4'd2;
            end
            CMD_CHIP_B:
            begin
                cb[0] = CHIP_B_OP;
                cb[1] = item_reg.address[7:0];
                cb[2] = item_reg.value;
                cn    = 4'd3;
            end
            CMD_CHIP_D:
            begin
                cb[0] = item_reg.address[7:0] + CHIP_D_OP - CHIP_D_BASE[7:0];
                cb[1] = item_reg.value;
                cn    = 4'd2;
            end
            CMD_CHIP_E:
            begin
                cb[0] = CHIP_E_OP;
                cb[1] = item_reg.address[7:0];
                cb[2] = item_reg.value;
                cn    = 4'd3;
            end
            CMD_CHIP_F:
            begin
                cb[0] = CHIP_F_OP;
                cb[1] = item_reg.address[7:0];
                cb[2] = item_reg.value;
                cn    = 4'd3;
            end
            CMD_END:
            begin
                cb[0] = END_MARK;
                cn    = 4'd1;
            end
            default:
            begin
                cn = 4'd0;
            end
        endcase
    end

    // Pack wait bytes, then command bytes.
    always_comb
    begin
        ser_load.valid = (state_reg == S_BUILD) && ser_ld_ready;
        ser_load.bytes = '0;
        ser_load.count = wn + cn;
        ci             = '0;
        for (int k = 0; k < MAX_BYTES; k++)
        begin
            ci = 4'(k) - wn;
            if (4'(k) < wn)
            begin
                ser_load.bytes[k] = (k < 6) ? wb[k < 6 ? k : 0] : 8'h00;
            end
            else if (ci < 4'd3)
            begin
                ser_load.bytes[k] = cb[ci[1:0]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sync_mode_reg <= 1'b0;
            init_done_reg <= 1'b0;
            synced_reg    <= '0;
            pending_reg   <= '0;
            window_reg    <= '1;
            emit_reg      <= 1'b0;
            flush_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sync_mode_reg <= sync_mode_next;
            init_done_reg <= init_done_next;
            synced_reg    <= synced_next;
            pending_reg   <= pending_next;
            window_reg    <= window_next;
            emit_reg      <= emit_next;
            flush_reg     <= flush_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        wait_reg <= wait_next;
        item_reg <= item_next;
    end

    a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ser_load.valid |-> (ser_ld_ready && state_reg == S_BUILD))
        else $error("log buffer loaded while not empty");

    a_slot_done_in_slot: assert property (@(posedge clk) disable iff (!rst_n)
        slot_rsp.done |-> state_reg == S_SLOT)
        else $error("bank slot result outside lookup state");

    a_init_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        init_done_reg |=> init_done_reg)
        else $error("init flag dropped");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ser_load.valid |-> (ser_load.count != 4'd0 && ser_load.count <= 4'd9))
        else $error("bad log byte count");
endmodule

// ----- hdl/rwle_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module rwle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ----- hdl/rwle_slot_finder.sv -----
// Bank-id table: sequential lookup and allocation over the table RAM.
// Depends on rwle_pkg and rwle_ram.
module rwle_slot_finder import rwle_pkg::*; #(
    parameter int MAX_BANKS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  slot_req_t slot_req,
    output slot_rsp_t slot_rsp
);
    localparam int CNT_W = $clog2(MAX_BANKS + 1);
    localparam int IDX_W = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_READ  = 2'd1;
    localparam logic [1:0] F_CMP   = 2'd2;
    localparam logic [1:0] F_ALLOC = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [7:0]       id_reg, id_next;
    logic             done_reg, done_next;
    logic [7:0]       slot_reg, slot_next;

    logic             wr_en;
    logic             rd_en;
    logic [7:0]       rd_data;

    rwle_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BANKS)
    ) u_bank_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (id_reg),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        id_next    = id_reg;
        done_next  = 1'b0;
        slot_next  = slot_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (slot_req.start)
                begin
                    id_next    = slot_req.id;
                    idx_next   = '0;
                    state_next = (count_reg == '0) ? F_ALLOC : F_READ;
                end
            end
            F_READ:
            begin
                rd_en      = 1'b1;
                state_next = F_CMP;
            end
            F_CMP:
            begin
                if (rd_data == id_reg)
                begin
                    done_next  = 1'b1;
                    slot_next  = 8'(idx_reg);
                    state_next = F_IDLE;
                end
                else if (idx_reg + 1'b1 == count_reg)
                begin
                    state_next = F_ALLOC;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = F_READ;
                end
            end
            F_ALLOC:
            begin
                done_next  = 1'b1;
                state_next = F_IDLE;
                if (count_reg == CNT_W'(MAX_BANKS))
                begin
                    slot_next = SLOT_NONE;
                end
                else
                begin
                    wr_en      = 1'b1;
                    slot_next  = 8'(count_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        id_reg   <= id_next;
        slot_reg <= slot_next;
    end

    assign slot_rsp.done = done_reg;
    assign slot_rsp.slot = slot_reg;
endmodule

// ----- hdl/rwle_serializer.sv -----
// Log byte buffer: loads up to nine bytes at once and shifts them out.
// Depends on rwle_pkg and rwle_stream_if.
module rwle_serializer import rwle_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  ser_load_t ld,
    output logic      ld_ready,
    rwle_stream_if.source log_byte
);
    logic [MAX_BYTES-1:0][7:0] data_reg, data_next;
    logic [3:0]                cnt_reg, cnt_next;
    logic                      pop;

    assign pop      = log_byte.valid && log_byte.ready;
    assign ld_ready = (cnt_reg == '0);

    always_comb
    begin
        data_next = data_reg;
        cnt_next  = cnt_reg;
        if (ld.valid && ld_ready)
        begin
            data_next = ld.bytes;
            cnt_next  = ld.count;
        end
        else if (pop)
        begin
            for (int k = 0; k < MAX_BYTES - 1; k++)
            begin
                data_next[k] = data_reg[k+1];
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign log_byte.valid            = (cnt_reg != '0);
    assign log_byte.payload.out_byte = data_reg[0];
    assign log_byte.payload.last     = (cnt_reg == 4'd1);
endmodule

// ----- bench/register_write_log_encoder_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for register_write_log_encoder: a directed table, then
// random register-write requests checked byte by byte against a built-in encoder.
// Depends on hdl/rwle_pkg.sv, hdl/rwle_stream_if.sv and the encoder RTL.
module register_write_log_encoder_test;
    import rwle_pkg::*;

    localparam int          MAX_BANKS     = 64;
    localparam int          LOG_SETTLE    = 200;
    localparam int          CYCLE_LIMIT   = 800000;
    localparam logic [3:0]  CMD_UNUSED_LO = 4'd11;
    localparam logic [3:0]  CMD_UNUSED_HI = 4'd15;

    typedef struct packed {
        req_t             req;
        logic             known;
        logic [1:0]       count;
        logic [0:2][7:0]  bytes;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic cfg_en;
    logic cfg_data;

    rwle_stream_if #(.payload_t(req_t)) write_req ();
    rwle_stream_if #(.payload_t(log_t)) log_byte ();

    register_write_log_encoder #(
        .MAX_BANKS(MAX_BANKS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_en(cfg_en),
        .cfg_data(cfg_data),
        .write_req(write_req),
        .log_byte(log_byte)
    );

    // encoder state
    logic        sync_by_ticks;
    logic        log_started;
    logic [31:0] logged_cycles;
    logic [31:0] wait_owed;
    logic [7:0]  window_id [4];
    logic [7:0]  bank_table [MAX_BANKS];
    int unsigned bank_used;

    logic [7:0]    encoded [$];
    log_t          log_expect [$];
    directed_row_t directed_rows [$];

    int unsigned send_idle;
    int unsigned recv_idle;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    logic [31:0] cycle_clock;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [7:0] bank_slot(input logic [7:0] id);
        for (int i = 0; i < bank_used; i++)
            if (bank_table[i] == id)
                return 8'(i);
        if (bank_used >= MAX_BANKS)
            return SLOT_NONE;
        bank_table[bank_used] = id;
        bank_used++;
        return 8'(bank_used - 1);
    endfunction

    function automatic void flush_wait(input logic [31:0] now);
        logic [31:0] l;
        if (!log_started)
            return;
        if (!sync_by_ticks)
            wait_owed = now - logged_cycles;
        if (wait_owed == 0)
            return;
        if (wait_owed == 32'd1)
            encoded.push_back(WAIT_SHORT);
        else if (wait_owed == 32'd2)
        begin
            encoded.push_back(WAIT_SHORT);
            encoded.push_back(WAIT_SHORT);
        end
        else
        begin
            l = wait_owed - 32'd3;
            encoded.push_back(WAIT_LONG);
            if (l > VARLEN_G4)
                encoded.push_back({4'b1000, l[31:28]});
            if (l > VARLEN_G3)
                encoded.push_back({1'b1, l[27:21]});
            if (l > VARLEN_G2)
                encoded.push_back({1'b1, l[20:14]});
            if (l > VARLEN_G1)
                encoded.push_back({1'b1, l[13:7]});
            encoded.push_back({1'b0, l[6:0]});
        end
        logged_cycles = logged_cycles + wait_owed;
        wait_owed = 32'd0;
    endfunction

    function automatic void encode_write(input req_t r);
        logic [7:0]  slot;
        logic [31:0] a_off;
        encoded.delete();
        case (r.cmd)
            CMD_TICK:
                if (sync_by_ticks && log_started)
                    wait_owed = wait_owed + 32'd1;
            CMD_BANK:
                if (r.address[3:0] >= 4'hC)
                begin
                    window_id[r.address[1:0]] = r.value;
                    slot = bank_slot(r.value);
                    flush_wait(r.cycle_now);
                    encoded.push_back(BANK_OP + 8'(r.address[1:0]));
                    encoded.push_back(slot);
                end
            CMD_BASE:
                if (r.address[15:12] < 4'hC)
                begin
                    flush_wait(r.cycle_now);
                    encoded.push_back(r.address[7:0]);
                    encoded.push_back(r.value);
                end
                else
                    slot = bank_slot(window_id[r.address[13:12]]);
            CMD_CHIP_A:
                if (r.address[11:0] < 12'd3)
                begin
                    a_off = 32'(r.address) - 32'(CHIP_A_BASE);
                    flush_wait(r.cycle_now);
                    encoded.push_back(CHIP_A_OP + 8'((a_off >> 12) * 32'd3)
                                      + 8'(r.address[1:0]));
                    encoded.push_back(r.value);
                end
            CMD_CHIP_B, CMD_CHIP_E, CMD_CHIP_F:
            begin
                flush_wait(r.cycle_now);
                encoded.push_back(r.cmd == CMD_CHIP_B ? CHIP_B_OP :
                                  r.cmd == CMD_CHIP_E ? CHIP_E_OP : CHIP_F_OP);
                encoded.push_back(r.address[7:0]);
                encoded.push_back(r.value);
            end
            CMD_CHIP_C:
            begin
                flush_wait(r.cycle_now);
                encoded.push_back(r.address[7:0]);
                encoded.push_back(r.value);
            end
            CMD_CHIP_D:
            begin
                flush_wait(r.cycle_now);
                encoded.push_back(CHIP_D_OP + r.address[7:0] - CHIP_D_BASE[7:0]);
                encoded.push_back(r.value);
            end
            CMD_INIT:
            begin
                log_started = 1'b1;
                logged_cycles = 32'd0;
            end
            CMD_END:
                encoded.push_back(END_MARK);
            default:
            begin
            end
        endcase
    endfunction

    function automatic void queue_log();
        log_t e;
        foreach (encoded[i])
        begin
            e.out_byte = encoded[i];
            e.last = (i == encoded.size() - 1);
            log_expect.push_back(e);
        end
    endfunction

    function automatic void add_row(input logic [3:0] c, input logic [15:0] a,
                                    input logic [7:0] v, input logic [31:0] t,
                                    input logic k, input logic [1:0] cnt,
                                    input logic [7:0] b0 = 8'h00,
                                    input logic [7:0] b1 = 8'h00,
                                    input logic [7:0] b2 = 8'h00);
        directed_row_t d;
        d.req.cmd = c;
        d.req.address = a;
        d.req.value = v;
        d.req.cycle_now = t;
        d.known = k;
        d.count = cnt;
        d.bytes = {b0, b1, b2};
        directed_rows.push_back(d);
    endfunction

    function automatic req_t random_write();
        req_t        r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60)
            cycle_clock = cycle_clock + 32'($urandom_range(3));
        else if (pick < 85)
            cycle_clock = cycle_clock + 32'($urandom_range(300));
        else if (pick < 96)
            cycle_clock = cycle_clock + 32'($urandom_range(1 << 22));
        else
            cycle_clock = $urandom;
        r.cycle_now = cycle_clock;
        r.address = 16'($urandom);
        r.value = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 25)
            r.cmd = CMD_TICK;
        else if (pick < 40)
        begin
            r.cmd = CMD_BANK;
            if ($urandom_range(99) < 80)
                r.address[3:0] = 4'($urandom_range(12, 15));
            if ($urandom_range(99) < 70)
                r.value = 8'($urandom_range(7) * 33);
        end
        else if (pick < 52)
        begin
            r.cmd = CMD_BASE;
            if ($urandom_range(99) < 30)
                r.address[15:14] = 2'b11;
        end
        else if (pick < 62)
        begin
            r.cmd = CMD_CHIP_A;
            if ($urandom_range(99) < 80)
                r.address = {4'($urandom_range(9, 11)), 10'd0, 2'($urandom_range(2))};
        end
        else if (pick < 86)
        begin
            r.cmd = CMD_CHIP_B + 4'($urandom_range(4));
            if (r.cmd == CMD_CHIP_D && $urandom_range(99) < 80)
                r.address = CHIP_D_BASE + 16'($urandom_range(31));
        end
        else if (pick < 91)
            r.cmd = CMD_INIT;
        else if (pick < 96)
            r.cmd = CMD_END;
        else
            r.cmd = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 64)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_log(input log_t got);
        log_t want;
        if (log_expect.size() == 0)
        begin
            report_mismatch($sformatf("unexpected log byte %02h", got.out_byte));
            return;
        end
        want = log_expect.pop_front();
        if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte,
                                      want.out_byte));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b on byte %02h", got.last,
                                      want.last, want.out_byte));
    endtask

    task automatic send_write(input req_t r);
        while ($urandom_range(99) < send_idle)
        begin
            write_req.valid <= 1'b0;
            @(posedge clk);
        end
        write_req.valid   <= 1'b1;
        write_req.payload <= r;
        @(posedge clk);
        while (!write_req.ready)
            @(posedge clk);
        encode_write(r);
    endtask

    task automatic wait_for_log();
        write_req.valid <= 1'b0;
        @(posedge clk);
        while (log_expect.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_sync(input logic mode);
        wait_for_log();
        repeat (LOG_SETTLE) @(posedge clk);
        cfg_en   <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        sync_by_ticks = mode;
        cfg_en <= 1'b0;
    endtask

    task automatic run_random(input int unsigned target);
        req_t        r;
        int unsigned counted;
        logic        ignored;
        counted = 0;
        while (counted < target)
        begin
            r = random_write();
            ignored = (r.cmd > CMD_END) || (r.cmd == CMD_TICK && !sync_by_ticks)
                      || (r.cmd == CMD_BANK && r.address[3:0] < 4'hC)
                      || (r.cmd == CMD_CHIP_A && r.address[11:0] >= 12'd3);
            send_write(r);
            queue_log();
            if (!ignored)
                counted++;
            // hold off until the log drains
            if (counted == target / 2 || $urandom_range(29) == 0)
                wait_for_log();
        end
    endtask

    initial
    begin
        log_byte.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (log_byte.valid && log_byte.ready)
                check_log(log_byte.payload);
            log_byte.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        req_t r;
        rst_n             <= 1'b0;
        cfg_en            <= 1'b0;
        cfg_data          <= 1'b0;
        write_req.valid   <= 1'b0;
        write_req.payload <= '0;
        sync_by_ticks  = 1'b0;
        log_started    = 1'b0;
        logged_cycles  = 32'd0;
        wait_owed      = 32'd0;
        bank_used      = 0;
        mismatch_count = 0;
        cycle_clock    = 32'd0;
        send_idle      = 31;
        recv_idle      = 85;
        foreach (window_id[i])
            window_id[i] = 8'hFF;

        add_row(CMD_END,    16'h0000, 8'h00, 32'h0000_0000, 1, 1, END_MARK);
        add_row(CMD_CHIP_B, 16'h00FF, 8'h00, 32'hFFFF_FFFF, 1, 3, CHIP_B_OP, 8'hFF, 8'h00);
        add_row(CMD_TICK,   16'hFFFF, 8'hFF, 32'h0000_0000, 1, 0);
        add_row(CMD_UNUSED_HI, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1, 0);
        add_row(CMD_UNUSED_LO, 16'h0000, 8'h00, 32'h0000_0000, 1, 0);
        add_row(CMD_BANK,   16'h000B, 8'h12, 32'h0000_0000, 1, 0);
        add_row(CMD_BANK,   16'hFFFF, 8'hFF, 32'h0000_0000, 1, 2, 8'h3F, 8'h00);
        add_row(CMD_BASE,   16'hC000, 8'h00, 32'h0000_0000, 1, 0);
        add_row(CMD_BASE,   16'h0012, 8'hAB, 32'h0000_0000, 1, 2, 8'h12, 8'hAB);
        add_row(CMD_CHIP_A, 16'h9002, 8'h55, 32'h0000_0000, 1, 2, 8'h18, 8'h55);
        add_row(CMD_CHIP_A, 16'hB001, 8'h3C, 32'h0000_0000, 0, 0);
        add_row(CMD_CHIP_A, 16'h9003, 8'h01, 32'h0000_0000, 1, 0);
        add_row(CMD_CHIP_A, 16'h0000, 8'h80, 32'h0000_0000, 0, 0);
        add_row(CMD_CHIP_C, 16'h1234, 8'h77, 32'h0000_0000, 1, 2, 8'h34, 8'h77);
        add_row(CMD_CHIP_D, CHIP_D_BASE, 8'h01, 32'h0000_0000, 1, 2, CHIP_D_OP, 8'h01);
        add_row(CMD_CHIP_E, 16'h4011, 8'hFE, 32'h0000_0000, 1, 3, CHIP_E_OP, 8'h11, 8'hFE);
        add_row(CMD_CHIP_F, 16'h0007, 8'h7F, 32'h0000_0000, 1, 3, CHIP_F_OP, 8'h07, 8'h7F);
        add_row(CMD_INIT,   16'h0000, 8'h00, 32'h0000_1234, 1, 0);
        add_row(CMD_CHIP_C, 16'h0044, 8'h10, 32'h0000_0001, 0, 0);
        add_row(CMD_CHIP_C, 16'h0045, 8'h11, 32'h0000_0003, 0, 0);
        add_row(CMD_CHIP_C, 16'h0046, 8'h12, 32'h0000_0003, 0, 0);
        add_row(CMD_CHIP_B, 16'h0080, 8'h13, 32'h0000_0002, 0, 0);
        add_row(CMD_CHIP_C, 16'h0047, 8'h14, 32'h0000_0006, 0, 0);
        add_row(CMD_CHIP_C, 16'h0048, 8'h15, 32'h0000_0089, 0, 0);
        add_row(CMD_END,    16'h0000, 8'h00, 32'h0000_0089, 1, 1, END_MARK);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_sync(1'b0);

        foreach (directed_rows[i])
        begin
            send_write(directed_rows[i].req);
            if (directed_rows[i].known)
            begin
                encoded.delete();
                for (int k = 0; k < directed_rows[i].count; k++)
                    encoded.push_back(directed_rows[i].bytes[k]);
            end
            queue_log();
        end
        cycle_clock = 32'h0000_0089;
        run_random(20);

        set_sync(1'b1);
        send_idle = 85;
        recv_idle = 31;
        run_random(25);

        set_sync(1'b0);
        send_idle = 0;
        recv_idle = 0;
        // fill the bank table past its end with distinct ids
        for (int i = 0; i < 70; i++)
        begin
            r = random_write();
            r.cmd = CMD_BANK;
            r.address[3:0] = 4'($urandom_range(12, 15));
            r.value = 8'(i * 37 + 5);
            send_write(r);
            queue_log();
        end

        set_sync(1'b1);
        run_random(15);

        wait_for_log();
        repeat (LOG_SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
